/* sv/pwr_pkg.sv */
// ----------------------------------------------------------------------------
// Protobuf wire reader package
// Shared widths, result kinds, error causes and the default buffer limit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pwr_pkg;

  // Payload widths of the two channels.
  localparam int unsigned ByteW  = 8;
  localparam int unsigned AfterW = 16;
  localparam int unsigned KindW  = 3;
  localparam int unsigned FieldW = 32;
  localparam int unsigned WtypeW = 3;
  localparam int unsigned ValueW = 64;
  localparam int unsigned CauseW = 3;

  // Default upper bound on the buffer length.
  localparam longint unsigned MaxBufferLenDef = 64'd65536;

  // Kind of a delivered result.
  typedef enum logic [KindW-1:0] {
    KindVarint  = 3'd0,
    KindFixed64 = 3'd1,
    KindFixed32 = 3'd2,
    KindLength  = 3'd3,
    KindPayload = 3'd4,
    KindError   = 3'd5
  } result_kind_e;

  // Cause carried by an error result.
  typedef enum logic [CauseW-1:0] {
    CauseNone      = 3'd0,
    CauseTruncated = 3'd1,
    CauseOverlong  = 3'd2,
    CauseBadType   = 3'd3,
    CauseTooLong   = 3'd4
  } err_cause_e;

  // Wire types that the tag may carry.
  localparam logic [WtypeW-1:0] WtVarint  = 3'd0;
  localparam logic [WtypeW-1:0] WtFixed64 = 3'd1;
  localparam logic [WtypeW-1:0] WtLength  = 3'd2;
  localparam logic [WtypeW-1:0] WtFixed32 = 3'd5;

  // One result as held in the output stages.
  typedef struct packed {
    result_kind_e             kind;
    logic [FieldW-1:0]        field_number;
    logic [WtypeW-1:0]        wire_type;
    logic [ValueW-1:0]        field_value;
    logic                     payload_last;
    logic                     buffer_end;
    err_cause_e               cause;
  } result_t;

endpackage : pwr_pkg

`default_nettype wire

/* sv/pwr_in_if.sv */
// ----------------------------------------------------------------------------
// Protobuf wire reader input channel
// Valid/ready channel that carries one byte of the encoded buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface pwr_in_if;
  import pwr_pkg::*;

  logic              valid;
  logic              ready;
  logic [ByteW-1:0]  data_byte;
  logic              first_of_buffer;
  logic [AfterW-1:0] bytes_after;

  modport source (output valid, output data_byte, output first_of_buffer,
                  output bytes_after, input ready);
  modport sink   (input valid, input data_byte, input first_of_buffer,
                  input bytes_after, output ready);

endinterface : pwr_in_if

`default_nettype wire

/* sv/pwr_out_if.sv */
// ----------------------------------------------------------------------------
// Protobuf wire reader output channel
// Valid/ready channel that carries one decoded field, payload byte or error.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface pwr_out_if;
  import pwr_pkg::*;

  logic              valid;
  logic              ready;
  logic [KindW-1:0]  result_kind;
  logic [FieldW-1:0] field_number;
  logic [WtypeW-1:0] wire_type;
  logic [ValueW-1:0] field_value;
  logic              payload_last;
  logic              buffer_end;
  logic [CauseW-1:0] error_cause;

  modport source (output valid, output result_kind, output field_number,
                  output wire_type, output field_value, output payload_last,
                  output buffer_end, output error_cause, input ready);
  modport sink   (input valid, input result_kind, input field_number,
                  input wire_type, input field_value, input payload_last,
                  input buffer_end, input error_cause, output ready);

endinterface : pwr_out_if

`default_nettype wire

/* sv/protobuf_wire_reader_top.sv */
// ----------------------------------------------------------------------------
// Protobuf wire reader
// Decodes a protobuf wire-format buffer one byte per request.
// ----------------------------------------------------------------------------
// The block takes one buffer byte per cycle and turns tags, varints, fixed
// 32/64-bit values and length-delimited headers with their payload bytes into
// at most one result per byte. A byte is decoded in the cycle it is accepted:
// the parse state updates in a single step and the result is registered in
// the output register, or in the skid stage behind it while that register is
// held. The skid stage holds one entry; input ready only drops while that
// stage is full, so the sustained rate is one byte per cycle whenever the
// consumer keeps up. Any error gives one error result and silences the block
// until a byte with first_of_buffer set starts a new buffer.
`timescale 1ns / 1ps
`default_nettype none

module protobuf_wire_reader_top #(
  parameter longint unsigned MAX_BUFFER_LEN = pwr_pkg::MaxBufferLenDef
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  pwr_in_if.sink     in_i,
  pwr_out_if.source  out_o
);
  import pwr_pkg::*;

  typedef enum logic [2:0] {
    PhTag     = 3'd0,
    PhVarint  = 3'd1,
    PhFixed   = 3'd2,
    PhLength  = 3'd3,
    PhPayload = 3'd4
  } phase_e;

  localparam logic [32:0] AfterCap = 33'(MAX_BUFFER_LEN - 64'd1);

  // Parse state.
  phase_e              phase_q, phase_d;
  logic [ValueW-1:0]   acc_q, acc_d;
  logic [3:0]          pos_q, pos_d;
  logic [FieldW-1:0]   fnum_q, fnum_d;
  logic [WtypeW-1:0]   wtype_q, wtype_d;
  logic [AfterW-1:0]   rem_q, rem_d;
  logic                sticky_q, sticky_d;

  // Output register and skid stage.
  logic                out_valid_q;
  logic                skid_valid_q;
  result_t             out_q;
  result_t             skid_q;

  // Decode signals.
  phase_e              c_phase;
  logic [ValueW-1:0]   c_acc;
  logic [3:0]          c_pos;
  logic [FieldW-1:0]   c_fnum;
  logic [WtypeW-1:0]   c_wtype;
  logic [AfterW-1:0]   c_rem;
  logic                c_sticky;
  logic [AfterW-1:0]   after_c;
  logic                end_c;
  logic [3:0]          pos_lim;
  logic [5:0]          vi_shamt;
  logic [ValueW-1:0]   vi_acc;
  logic                vi_done;
  logic                vi_over;
  logic [ValueW-1:0]   fx_acc;
  logic [3:0]          fx_pos;
  logic [3:0]          fx_need;
  logic [AfterW-1:0]   rem_dec;
  logic                pay_last;
  logic                fail;
  err_cause_e          fail_cause;
  logic                res_valid;
  result_t             res;
  logic                in_fire;
  logic                out_take;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_take = out_valid_q && out_o.ready;
  assign in_i.ready = !skid_valid_q;

  // Clamp the byte count to the buffer limit and spot the last byte.
  always_comb begin
    if (33'(in_i.bytes_after) > AfterCap) begin
      after_c = AfterCap[AfterW-1:0];
    end else begin
      after_c = in_i.bytes_after;
    end
    end_c = (after_c == '0);
  end

  // A new buffer clears the parse state and the sticky error first.
  always_comb begin
    if (in_i.first_of_buffer) begin
      c_phase  = PhTag;
      c_acc    = '0;
      c_pos    = '0;
      c_fnum   = '0;
      c_wtype  = '0;
      c_rem    = '0;
      c_sticky = 1'b0;
    end else begin
      c_phase  = phase_q;
      c_acc    = acc_q;
      c_pos    = pos_q;
      c_fnum   = fnum_q;
      c_wtype  = wtype_q;
      c_rem    = rem_q;
      c_sticky = sticky_q;
    end
  end

  // Varint and fixed-value byte merge.
  always_comb begin
    pos_lim  = (c_pos > 4'd9) ? 4'd9 : c_pos;
    vi_shamt = {2'b00, pos_lim} * 6'd7;
    vi_acc   = c_acc | ({57'd0, in_i.data_byte[6:0]} << vi_shamt);
    vi_done  = !in_i.data_byte[7];
    vi_over  = in_i.data_byte[7] && (c_pos >= 4'd9);
    fx_acc   = c_acc | ({56'd0, in_i.data_byte} << {c_pos[2:0], 3'b000});
    fx_pos   = c_pos + 4'd1;
    fx_need  = (c_wtype == WtFixed64) ? 4'd8 : 4'd4;
    rem_dec  = (c_rem != '0) ? (c_rem - 16'd1) : c_rem;
    pay_last = (rem_dec == '0);
  end

  // Next parse state and result for the byte at the input.
  always_comb begin
    phase_d    = c_phase;
    acc_d      = c_acc;
    pos_d      = c_pos;
    fnum_d     = c_fnum;
    wtype_d    = c_wtype;
    rem_d      = c_rem;
    sticky_d   = c_sticky;
    fail       = 1'b0;
    fail_cause = CauseNone;
    res_valid  = 1'b0;
    res.kind         = KindVarint;
    res.field_number = c_fnum;
    res.wire_type    = c_wtype;
    res.field_value  = '0;
    res.payload_last = 1'b0;
    res.buffer_end   = 1'b0;
    res.cause        = CauseNone;

    if (!c_sticky) begin
      case (c_phase)
        PhVarint, PhLength: begin
          if (vi_over) begin
            fail       = 1'b1;
            fail_cause = CauseOverlong;
          end else if (!vi_done) begin
            acc_d = vi_acc;
            pos_d = c_pos + 4'd1;
            if (end_c) begin
              fail       = 1'b1;
              fail_cause = CauseTruncated;
            end
          end else if (c_phase == PhVarint) begin
            res_valid       = 1'b1;
            res.kind        = KindVarint;
            res.field_value = vi_acc;
            res.buffer_end  = end_c;
            phase_d         = PhTag;
            acc_d           = '0;
            pos_d           = '0;
          end else if (vi_acc > {48'd0, after_c}) begin
            fail       = 1'b1;
            fail_cause = CauseTooLong;
          end else begin
            res_valid       = 1'b1;
            res.kind        = KindLength;
            res.field_value = vi_acc;
            res.buffer_end  = (vi_acc == '0) && end_c;
            acc_d           = '0;
            pos_d           = '0;
            if (vi_acc != '0) begin
              rem_d   = vi_acc[AfterW-1:0];
              phase_d = PhPayload;
            end else begin
              phase_d = PhTag;
            end
          end
        end

        PhFixed: begin
          if (fx_pos < fx_need) begin
            acc_d = fx_acc;
            pos_d = fx_pos;
            if (end_c) begin
              fail       = 1'b1;
              fail_cause = CauseTruncated;
            end
          end else begin
            res_valid       = 1'b1;
            res.kind        = (fx_need == 4'd8) ? KindFixed64 : KindFixed32;
            res.field_value = fx_acc;
            res.buffer_end  = end_c;
            acc_d           = '0;
            pos_d           = '0;
            phase_d         = PhTag;
          end
        end

        PhPayload: begin
          rem_d = rem_dec;
          if (!pay_last && end_c) begin
            fail       = 1'b1;
            fail_cause = CauseTruncated;
          end else begin
            res_valid        = 1'b1;
            res.kind         = KindPayload;
            res.field_value  = {56'd0, in_i.data_byte};
            res.payload_last = pay_last;
            res.buffer_end   = pay_last && end_c;
            if (pay_last) begin
              phase_d = PhTag;
            end
          end
        end

        default: begin
          // Tag varint; a complete tag alone gives no result.
          phase_d = PhTag;
          if (vi_over) begin
            fail       = 1'b1;
            fail_cause = CauseOverlong;
          end else if (!vi_done) begin
            acc_d = vi_acc;
            pos_d = c_pos + 4'd1;
            if (end_c) begin
              fail       = 1'b1;
              fail_cause = CauseTruncated;
            end
          end else begin
            fnum_d  = vi_acc[FieldW+2:3];
            wtype_d = vi_acc[WtypeW-1:0];
            acc_d   = '0;
            pos_d   = '0;
            if (vi_acc[WtypeW-1:0] != WtVarint && vi_acc[WtypeW-1:0] != WtFixed64 &&
                vi_acc[WtypeW-1:0] != WtLength && vi_acc[WtypeW-1:0] != WtFixed32) begin
              fail       = 1'b1;
              fail_cause = CauseBadType;
            end else if (end_c) begin
              fail       = 1'b1;
              fail_cause = CauseTruncated;
            end else if (vi_acc[WtypeW-1:0] == WtVarint) begin
              phase_d = PhVarint;
            end else if (vi_acc[WtypeW-1:0] == WtLength) begin
              phase_d = PhLength;
            end else begin
              phase_d = PhFixed;
            end
          end
        end
      endcase
    end

    // An error clears the parse state and blanks the result fields.
    if (fail) begin
      phase_d          = PhTag;
      acc_d            = '0;
      pos_d            = '0;
      fnum_d           = '0;
      wtype_d          = '0;
      rem_d            = '0;
      sticky_d         = 1'b1;
      res_valid        = 1'b1;
      res.kind         = KindError;
      res.field_number = '0;
      res.wire_type    = '0;
      res.field_value  = '0;
      res.payload_last = 1'b0;
      res.buffer_end   = 1'b0;
      res.cause        = fail_cause;
    end
  end

  // Parse state registers, updated on each accepted request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhTag;
      acc_q    <= '0;
      pos_q    <= '0;
      fnum_q   <= '0;
      wtype_q  <= '0;
      rem_q    <= '0;
      sticky_q <= 1'b0;
    end else if (in_fire) begin
      phase_q  <= phase_d;
      acc_q    <= acc_d;
      pos_q    <= pos_d;
      fnum_q   <= fnum_d;
      wtype_q  <= wtype_d;
      rem_q    <= rem_d;
      sticky_q <= sticky_d;
    end
  end

  // Output register and skid stage occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_take) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_fire && res_valid;
      end
    end else if (in_fire && res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Result payload moves without reset.
  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_take) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_fire && res_valid) begin
        out_q <= res;
      end
    end else if (in_fire && res_valid) begin
      skid_q <= res;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.result_kind  = out_q.kind;
  assign out_o.field_number = out_q.field_number;
  assign out_o.wire_type    = out_q.wire_type;
  assign out_o.field_value  = out_q.field_value;
  assign out_o.payload_last = out_q.payload_last;
  assign out_o.buffer_end   = out_q.buffer_end;
  assign out_o.error_cause  = out_q.cause;

  // The skid stage only fills behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage full while output register is empty");

  // A payload phase always has bytes still owed.
  a_payload_owed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhPayload) |-> (rem_q != '0))
    else $error("payload phase with no bytes remaining");

  // Varint byte count never passes the tenth byte.
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= 4'd9)
    else $error("varint byte position out of range");

  // The sticky error leaves a cleared parse state.
  a_sticky_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sticky_q |-> (phase_q == PhTag && acc_q == '0 && pos_q == '0))
    else $error("parse state not cleared under sticky error");

  // While the error is sticky, only a new buffer can produce a result.
  a_sticky_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && sticky_q && !in_i.first_of_buffer) |-> !res_valid)
    else $error("result produced under sticky error");

endmodule : protobuf_wire_reader_top

`default_nettype wire

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// Protobuf wire reader testbench
// Sends encoded buffers byte by byte and checks every decoded result in order.
// ----------------------------------------------------------------------------
// Directed tests cover the value extremes, each wire type and every error
// cause. A long random phase then follows. It sends mostly well-formed buffers
// with random fields and some broken buffers and raw noise. A behavioral
// decoder predicts each result as its byte is accepted. A checker process
// compares each delivered result with the oldest prediction. Both channels
// idle at random.
`timescale 1ns / 1ps

module tb_top;
  import pwr_pkg::*;

  // Wire types that the decoder must reject.
  localparam logic [WtypeW-1:0] WtStartGroup = 3'd3;
  localparam logic [WtypeW-1:0] WtEndGroup   = 3'd4;
  localparam logic [WtypeW-1:0] WtReserved6  = 3'd6;
  localparam logic [WtypeW-1:0] WtReserved7  = 3'd7;

  localparam int RandomBytes = 1250;

  typedef enum logic [2:0] {
    PhaseTag,
    PhaseVarint,
    PhaseFixed,
    PhaseLength,
    PhasePayload
  } decode_phase_e;

  typedef enum logic [1:0] {
    VarintMore,
    VarintDone,
    VarintOverlong
  } varint_status_e;

  logic clk;
  logic rst_n;

  pwr_in_if  in_if ();
  pwr_out_if out_if ();

  protobuf_wire_reader_top dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Decoder state of the prediction.
  decode_phase_e     phase;
  logic [ValueW-1:0] value_acc;
  logic [3:0]        byte_pos;
  logic [FieldW-1:0] held_field;
  logic [WtypeW-1:0] held_wtype;
  logic [AfterW-1:0] payload_left;
  bit                error_latched;

  result_t     expected_results[$];
  logic [7:0]  wire_bytes[$];
  int          decoded_bytes = 0;
  int          mismatch_count = 0;
  int          in_calm_left = 0;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard limit on the run time.
  initial begin
    #2_000_000;
    $display("protobuf_wire_reader_top: mismatch");
    $finish;
  end

  function automatic void reset_parse();
    phase        = PhaseTag;
    value_acc    = '0;
    byte_pos     = '0;
    held_field   = '0;
    held_wtype   = '0;
    payload_left = '0;
  endfunction

  // Queue one predicted result; error results carry only kind and cause.
  function automatic void queue_result(input result_kind_e kind,
                                       input logic [ValueW-1:0] value,
                                       input bit last, input bit at_end,
                                       input err_cause_e cause);
    result_t r;
    r.kind  = kind;
    r.cause = cause;
    if (kind == KindError) begin
      r.field_number = '0;
      r.wire_type    = '0;
      r.field_value  = '0;
      r.payload_last = 1'b0;
      r.buffer_end   = 1'b0;
    end else begin
      r.field_number = held_field;
      r.wire_type    = held_wtype;
      r.field_value  = value;
      r.payload_last = last;
      r.buffer_end   = at_end;
    end
    expected_results.push_back(r);
  endfunction

  function automatic void raise_error(input err_cause_e cause);
    error_latched = 1'b1;
    reset_parse();
    queue_result(KindError, '0, 1'b0, 1'b0, cause);
  endfunction

  // Adds seven value bits; bits beyond bit 63 fall off the shift.
  function automatic varint_status_e varint_step(input logic [7:0] b);
    int unsigned sh;
    sh = 7 * ((byte_pos > 4'd9) ? 9 : int'(byte_pos));
    value_acc |= {57'd0, b[6:0]} << sh;
    if (!b[7]) return VarintDone;
    if (byte_pos >= 4'd9) return VarintOverlong;
    byte_pos++;
    return VarintMore;
  endfunction

  // Predict the result, if any, of one accepted byte.
  function automatic void predict_byte(input logic [7:0] b, input bit first,
                                       input logic [AfterW-1:0] after);
    bit             at_end;
    bit             last;
    int             need;
    varint_status_e st;
    at_end = (after == 0);
    if (first) begin
      reset_parse();
      error_latched = 1'b0;
    end
    if (error_latched) return;
    decoded_bytes++;
    case (phase)
      PhaseVarint, PhaseLength: begin
        st = varint_step(b);
        if (st == VarintOverlong) begin
          raise_error(CauseOverlong);
        end else if (st == VarintMore) begin
          if (at_end) raise_error(CauseTruncated);
        end else if (phase == PhaseVarint) begin
          queue_result(KindVarint, value_acc, 1'b0, at_end, CauseNone);
          phase     = PhaseTag;
          value_acc = '0;
          byte_pos  = '0;
        end else if (value_acc > {48'd0, after}) begin
          raise_error(CauseTooLong);
        end else begin
          queue_result(KindLength, value_acc, 1'b0, value_acc == 0 && at_end,
                       CauseNone);
          payload_left = value_acc[AfterW-1:0];
          phase        = (value_acc != 0) ? PhasePayload : PhaseTag;
          value_acc    = '0;
          byte_pos     = '0;
        end
      end
      PhaseFixed: begin
        need = (held_wtype == WtFixed64) ? 8 : 4;
        value_acc |= {56'd0, b} << (8 * byte_pos[2:0]);
        byte_pos++;
        if (byte_pos < need) begin
          if (at_end) raise_error(CauseTruncated);
        end else begin
          queue_result((need == 8) ? KindFixed64 : KindFixed32, value_acc,
                       1'b0, at_end, CauseNone);
          value_acc = '0;
          byte_pos  = '0;
          phase     = PhaseTag;
        end
      end
      PhasePayload: begin
        if (payload_left > 0) payload_left--;
        last = (payload_left == 0);
        if (!last && at_end) begin
          raise_error(CauseTruncated);
        end else begin
          queue_result(KindPayload, {56'd0, b}, last, last && at_end, CauseNone);
          if (last) phase = PhaseTag;
        end
      end
      default: begin
        phase = PhaseTag;
        st = varint_step(b);
        if (st == VarintOverlong) begin
          raise_error(CauseOverlong);
        end else if (st == VarintMore) begin
          if (at_end) raise_error(CauseTruncated);
        end else begin
          held_field = value_acc[FieldW+2:3];
          held_wtype = value_acc[2:0];
          value_acc  = '0;
          byte_pos   = '0;
          if (!(held_wtype inside {WtVarint, WtFixed64, WtLength, WtFixed32})) begin
            raise_error(CauseBadType);
          end else if (at_end) begin
            raise_error(CauseTruncated);
          end else if (held_wtype == WtVarint) begin
            phase = PhaseVarint;
          end else if (held_wtype == WtLength) begin
            phase = PhaseLength;
          end else begin
            phase = PhaseFixed;
          end
        end
      end
    endcase
  endfunction

  // Encoding helpers that fill the staging buffer.
  function automatic void put_varint(input logic [63:0] v, input int min_len);
    logic [7:0] b;
    int         n;
    n = 0;
    do begin
      b = {1'b0, v[6:0]};
      v = v >> 7;
      n++;
      if (v != 0 || n < min_len) b[7] = 1'b1;
      wire_bytes.push_back(b);
    end while (v != 0 || n < min_len);
  endfunction

  function automatic void put_tag(input logic [60:0] field, input logic [2:0] wt);
    put_varint({field, wt}, 1);
  endfunction

  function automatic void put_raw(input logic [63:0] v, input int count);
    for (int i = 0; i < count; i++) wire_bytes.push_back(v[8*i +: 8]);
  endfunction

  // Input gaps: mostly none or short, a few long, with calm stretches.
  function automatic int next_input_gap();
    int r;
    if (in_calm_left > 0) begin
      in_calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      in_calm_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Send one byte request and predict its result once accepted.
  task automatic send_byte(input logic [7:0] data, input bit first,
                           input logic [AfterW-1:0] after);
    int gap;
    gap = next_input_gap();
    if (gap > 0) begin
      in_if.valid     <= 1'b0;
      in_if.data_byte <= 8'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_if.valid           <= 1'b1;
    in_if.data_byte       <= data;
    in_if.first_of_buffer <= first;
    in_if.bytes_after     <= after;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    predict_byte(data, first, after);
  endtask

  // Send the staging buffer; extra inflates the count of bytes that follow.
  task automatic send_buffer(input bit mark_first, input int extra);
    int len;
    int after;
    len = wire_bytes.size();
    for (int i = 0; i < len; i++) begin
      after = len - 1 - i + extra;
      if (after > 65535) after = 65535;
      send_byte(wire_bytes[i], mark_first && i == 0, after[AfterW-1:0]);
    end
    wire_bytes.delete();
  endtask

  // Append one random field; with allow_bad it may break the encoding.
  function automatic void add_random_field(input bit allow_bad);
    logic [60:0] field;
    logic [2:0]  wt;
    logic [63:0] v;
    int          r;
    int          bits;
    int          pad;
    int          n;
    r = $urandom_range(0, 99);
    if (r < 50) field = 61'($urandom_range(0, 15));
    else if (r < 80) field = 61'($urandom_range(16, 1 << 20));
    else if (r < 95) field = {29'd0, 32'($urandom)};
    else field = {29'($urandom), 32'($urandom)};
    case ($urandom_range(0, 3))
      0:       wt = WtVarint;
      1:       wt = WtFixed64;
      2:       wt = WtLength;
      default: wt = WtFixed32;
    endcase
    if (allow_bad && $urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 3))
        0:       wt = WtStartGroup;
        1:       wt = WtEndGroup;
        2:       wt = WtReserved6;
        default: wt = WtReserved7;
      endcase
    end
    pad = ($urandom_range(0, 19) == 0) ? $urandom_range(1, allow_bad ? 11 : 10) : 1;
    put_varint({field, wt}, pad);
    pad = ($urandom_range(0, 14) == 0) ? $urandom_range(1, allow_bad ? 11 : 10) : 1;
    case (wt)
      WtVarint: begin
        bits = $urandom_range(0, 64);
        v = {32'($urandom), 32'($urandom)};
        if (bits < 64) v = v & ((64'd1 << bits) - 64'd1);
        put_varint(v, pad);
      end
      WtFixed64: put_raw({32'($urandom), 32'($urandom)}, 8);
      WtFixed32: put_raw({32'd0, 32'($urandom)}, 4);
      WtLength: begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
        put_varint(64'(n), pad);
        repeat (n) wire_bytes.push_back(8'($urandom));
      end
      default: begin
        if ($urandom_range(0, 1) == 0) wire_bytes.push_back(8'($urandom));
      end
    endcase
  endfunction

  // Largest field number and value, and the smallest value.
  task automatic test_varint_extremes();
    put_tag(61'hFFFF_FFFF, WtVarint);
    put_varint(64'hFFFF_FFFF_FFFF_FFFF, 1);
    put_tag(61'd1, WtVarint);
    put_varint(64'd0, 1);
    send_buffer(1'b1, 0);
  endtask

  task automatic test_field_zero();
    put_tag(61'd0, WtVarint);
    put_varint(64'd1, 1);
    send_buffer(1'b1, 0);
  endtask

  task automatic test_fixed_values();
    put_tag(61'd2, WtFixed32);
    put_raw(64'h0000_0000_FFFF_FFFF, 4);
    put_tag(61'd3, WtFixed64);
    put_raw({32'($urandom), 32'($urandom)}, 8);
    send_buffer(1'b1, 0);
  endtask

  // A payload of two bytes, then an empty length field that ends the buffer.
  task automatic test_length_fields();
    put_tag(61'd4, WtLength);
    put_varint(64'd2, 1);
    put_raw(64'h0000_0000_0000_FF00, 2);
    put_tag(61'd5, WtLength);
    put_varint(64'd0, 1);
    send_buffer(1'b1, 0);
  endtask

  // Each rejected wire type, with a trailing byte that must stay silent.
  task automatic test_bad_wire_types();
    logic [2:0] bad_types[4];
    bad_types = '{WtStartGroup, WtEndGroup, WtReserved6, WtReserved7};
    foreach (bad_types[i]) begin
      put_tag(61'd9, bad_types[i]);
      wire_bytes.push_back(8'h01);
      send_buffer(1'b1, 0);
    end
  endtask

  task automatic test_overlong_varint();
    put_tag(61'd1, WtVarint);
    repeat (10) wire_bytes.push_back(8'hFF);
    wire_bytes.push_back(8'h01);
    send_buffer(1'b1, 0);
  endtask

  // A tag alone, a cut varint, a cut payload and a cut fixed value.
  task automatic test_truncation();
    put_tag(61'd1, WtVarint);
    send_buffer(1'b1, 0);
    put_tag(61'd1, WtVarint);
    wire_bytes.push_back(8'h80);
    send_buffer(1'b1, 0);
    put_tag(61'd1, WtLength);
    put_varint(64'd3, 1);
    wire_bytes.push_back(8'hAA);
    send_buffer(1'b1, 0);
    put_tag(61'd1, WtFixed64);
    put_raw(64'h0000_0000_0003_0201, 3);
    send_buffer(1'b1, 0);
  endtask

  task automatic test_length_too_long();
    put_tag(61'd1, WtLength);
    put_varint(64'd5, 1);
    wire_bytes.push_back(8'h11);
    send_buffer(1'b1, 0);
  endtask

  // After a clean end, decoding goes on without a new buffer mark.
  task automatic test_trailing_bytes();
    put_tag(61'd6, WtVarint);
    put_varint(64'd5, 1);
    send_buffer(1'b1, 0);
    put_tag(61'd7, WtVarint);
    put_varint(64'd7, 1);
    send_buffer(1'b0, 0);
  endtask

  // Mostly well-formed buffers, mixed with broken buffers and raw noise.
  task automatic test_random_traffic();
    int start;
    int r;
    int n;
    start = decoded_bytes;
    while (decoded_bytes - start < RandomBytes) begin
      r = $urandom_range(0, 99);
      if (r < 78) begin
        repeat ($urandom_range(1, 6)) add_random_field(1'b0);
        send_buffer($urandom_range(0, 19) != 0,
                    ($urandom_range(0, 9) == 0) ? $urandom_range(1, 65535) : 0);
      end else if (r < 90) begin
        repeat ($urandom_range(1, 4)) add_random_field(1'b1);
        case ($urandom_range(0, 2))
          0: begin
            n = $urandom_range(1, wire_bytes.size());
            repeat (n) if (wire_bytes.size() > 1) void'(wire_bytes.pop_back());
          end
          1: wire_bytes[$urandom_range(0, wire_bytes.size() - 1)] = 8'($urandom);
          default: ;
        endcase
        send_buffer(1'b1, 0);
      end else begin
        repeat ($urandom_range(1, 8))
          send_byte(8'($urandom), $urandom_range(0, 4) == 0, 16'($urandom));
      end
    end
  endtask

  // Output pacing: mostly ready, short and long stalls, calm stretches.
  initial begin : sink_pacing
    int stall_left;
    int calm_left;
    int r;
    bit rdy;
    out_if.ready = 1'b0;
    stall_left   = 0;
    calm_left    = 0;
    forever begin
      @(posedge clk);
      rdy = 1'b1;
      if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if (calm_left > 0) begin
        calm_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          calm_left = $urandom_range(30, 120);
        end else if (r < 25) begin
          rdy = 1'b0;
          stall_left = $urandom_range(0, 2);
        end else if (r < 29) begin
          rdy = 1'b0;
          stall_left = $urandom_range(8, 40);
        end
      end
      out_if.ready <= rdy;
    end
  end

  // Compare each delivered result with the oldest prediction.
  always @(posedge clk) begin : check_results
    result_t want;
    result_t got;
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      got.kind         = result_kind_e'(out_if.result_kind);
      got.field_number = out_if.field_number;
      got.wire_type    = out_if.wire_type;
      got.field_value  = out_if.field_value;
      got.payload_last = out_if.payload_last;
      got.buffer_end   = out_if.buffer_end;
      got.cause        = err_cause_e'(out_if.error_cause);
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: kind %0d field %h value %h cause %0d",
                   got.kind, got.field_number, got.field_value, got.cause);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"result differs: expected kind %0d field %h type %0d value %h ",
                      "last %b end %b cause %0d; got kind %0d field %h type %0d ",
                      "value %h last %b end %b cause %0d"},
                     want.kind, want.field_number, want.wire_type, want.field_value,
                     want.payload_last, want.buffer_end, want.cause,
                     got.kind, got.field_number, got.wire_type, got.field_value,
                     got.payload_last, got.buffer_end, got.cause);
        end
      end
    end
  end

  // Main sequence.
  initial begin
    rst_n                 = 1'b0;
    in_if.valid           = 1'b0;
    in_if.data_byte       = '0;
    in_if.first_of_buffer = 1'b0;
    in_if.bytes_after     = '0;
    reset_parse();
    error_latched = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_varint_extremes();
    test_field_zero();
    test_fixed_values();
    test_length_fields();
    test_bad_wire_types();
    test_overlong_varint();
    test_truncation();
    test_length_too_long();
    test_trailing_bytes();
    test_random_traffic();

    in_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("protobuf_wire_reader_top: match");
    end else begin
      $display("protobuf_wire_reader_top: mismatch");
    end
    $finish;
  end

endmodule : tb_top
